@@ design/event_triggered_state_feedback_core_assert.svh @@
// assertion macros for the event-triggered state feedback core
// needs signals named clock and reset in the module that includes it
`ifndef EVENT_TRIGGERED_STATE_FEEDBACK_CORE_ASSERT_SVH
`define EVENT_TRIGGERED_STATE_FEEDBACK_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ETSF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ETSF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/etsf_pkg.sv @@
// shared widths, codes, state enum and structs of the event-triggered core
// no dependencies
package etsf_pkg;

   localparam int STATE_W   = 16;
   localparam int COEF_W    = 16;
   localparam int CFG_W     = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CTRL_W    = 34;
   localparam int CNT_W     = 16;
   localparam int DIFF_W    = STATE_W + 1;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = DIFF_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 52;
   localparam int GPROD_W   = 2 * STATE_W;
   localparam int STEP_W    = 4;
   localparam int TERM_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PSI         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XI          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IET_MAX     = 3'd4;

   localparam logic [CNT_W-1:0] IET_RESET = 16'd100;

   // sequencer step plan
   localparam logic [STEP_W-1:0] STEP_ACC_FIRST   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ACC_LAST    = 4'd12;
   localparam logic [STEP_W-1:0] STEP_GAIN_SECOND = 4'd13;

   // term numbers within the step plan
   localparam logic [TERM_W-1:0] TERM_PSI_00 = 3'd0;
   localparam logic [TERM_W-1:0] TERM_PSI_01 = 3'd1;
   localparam logic [TERM_W-1:0] TERM_PSI_11 = 3'd2;
   localparam logic [TERM_W-1:0] TERM_XI_00  = 3'd3;
   localparam logic [TERM_W-1:0] TERM_XI_01  = 3'd4;
   localparam logic [TERM_W-1:0] TERM_XI_11  = 3'd5;
   localparam logic [TERM_W-1:0] TERM_GAIN   = 3'd6;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_FIRST = 2'd1,
      CAUSE_QUAD  = 2'd2,
      CAUSE_LIMIT = 2'd3
   } cause_type;

   typedef struct packed {
      logic [CFG_W-1:0]         psi;
      logic [CFG_W-1:0]         xi;
      logic signed [COEF_W-1:0] gain_first;
      logic signed [COEF_W-1:0] gain_second;
      logic [CNT_W-1:0]         iet_max;
   } csr_regs_type;

   typedef struct packed {
      logic              load_x;
      logic              mul_en;
      logic [STEP_W-1:0] step;
      logic              finish;
   } dp_ctrl_type;

endpackage

@@ design/etsf_channels.sv @@
// valid/ready channel interfaces: sample input, result output, register writes
// depends on etsf_pkg
interface etsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [etsf_pkg::STATE_W-1:0]  state_first;
   logic signed [etsf_pkg::STATE_W-1:0]  state_second;

   modport source (output valid, state_first, state_second, input ready);
   modport sink   (input valid, state_first, state_second, output ready);
endinterface

interface etsf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 event_fired;
   logic [1:0]                           event_cause;
   logic signed [etsf_pkg::CTRL_W-1:0]   control_value;
   logic signed [etsf_pkg::STATE_W-1:0]  held_first;
   logic signed [etsf_pkg::STATE_W-1:0]  held_second;

   modport source (output valid, event_fired, event_cause, control_value, held_first,
                   held_second, input ready);
   modport sink   (input valid, event_fired, event_cause, control_value, held_first,
                   held_second, output ready);
endinterface

interface etsf_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [etsf_pkg::CSR_IDX_W-1:0]       index;
   logic [etsf_pkg::CFG_W-1:0]           wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ design/etsf_csr.sv @@
// configuration register file: form coefficients, gains, inter-event limit
// depends on etsf_pkg and etsf_csr_if
module etsf_csr (
   input  logic                   clock,
   input  logic                   reset,
   etsf_csr_if.sink               csr,
   output etsf_pkg::csr_regs_type regs
);

   etsf_pkg::csr_regs_type regs_ff, regs_in;

   assign csr.ready = 1'b1;
   assign regs      = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            etsf_pkg::CSR_PSI:         regs_in.psi         = csr.wdata;
            etsf_pkg::CSR_XI:          regs_in.xi          = csr.wdata;
            etsf_pkg::CSR_GAIN_FIRST:  regs_in.gain_first  = csr.wdata[etsf_pkg::COEF_W-1:0];
            etsf_pkg::CSR_GAIN_SECOND: regs_in.gain_second = csr.wdata[etsf_pkg::COEF_W-1:0];
            etsf_pkg::CSR_IET_MAX:     regs_in.iet_max     = csr.wdata[etsf_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.psi         <= '0;
         regs_ff.xi          <= '0;
         regs_ff.gain_first  <= '0;
         regs_ff.gain_second <= '0;
         regs_ff.iet_max     <= etsf_pkg::IET_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

@@ design/etsf_seq.sv @@
// step sequencer: walks the shared multiplier through the fourteen products
// depends on etsf_pkg
module etsf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  req_ready,
   output etsf_pkg::dp_ctrl_type ctrl
);

   etsf_pkg::seq_state_type          state_ff, state_in;
   logic [etsf_pkg::STEP_W-1:0]      step_ff, step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etsf_pkg::SEQ_IDLE: begin
            if (req_valid) state_in = etsf_pkg::SEQ_RUN;
         end
         etsf_pkg::SEQ_RUN: begin
            if (step_ff == etsf_pkg::STEP_GAIN_SECOND) state_in = etsf_pkg::SEQ_DONE;
         end
         etsf_pkg::SEQ_DONE: begin
            if (out_free) state_in = etsf_pkg::SEQ_IDLE;
         end
         default: state_in = etsf_pkg::SEQ_IDLE;
      endcase
   end

   // step counter runs only while multiplying, holds through the final step
   always_comb begin
      unique case (state_ff)
         etsf_pkg::SEQ_RUN:  step_in = step_ff + etsf_pkg::STEP_W'(1);
         etsf_pkg::SEQ_DONE: step_in = step_ff;
         default:            step_in = '0;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = (state_ff == etsf_pkg::SEQ_IDLE);
      ctrl.load_x = (state_ff == etsf_pkg::SEQ_IDLE) && req_valid;
      ctrl.mul_en = (state_ff == etsf_pkg::SEQ_RUN);
      ctrl.step   = step_ff;
      ctrl.finish = (state_ff == etsf_pkg::SEQ_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etsf_pkg::SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ design/etsf_datapath.sv @@
// shared multiplier datapath: operand capture, 33x17 multiply, form accumulator
// depends on etsf_pkg
module etsf_datapath (
   input  logic                                 clock,
   input  etsf_pkg::dp_ctrl_type                ctrl,
   input  etsf_pkg::csr_regs_type               regs,
   input  logic signed [etsf_pkg::STATE_W-1:0]  state_first,
   input  logic signed [etsf_pkg::STATE_W-1:0]  state_second,
   input  logic signed [etsf_pkg::STATE_W-1:0]  latched_first,
   input  logic signed [etsf_pkg::STATE_W-1:0]  latched_second,
   output logic                                 acc_neg,
   output logic signed [etsf_pkg::CTRL_W-1:0]   ctrl_sum,
   output logic signed [etsf_pkg::STATE_W-1:0]  x_first,
   output logic signed [etsf_pkg::STATE_W-1:0]  x_second
);

   localparam int SW = etsf_pkg::STATE_W;
   localparam int DW = etsf_pkg::DIFF_W;
   localparam int AW = etsf_pkg::MUL_A_W;
   localparam int PW = etsf_pkg::PROD_W;
   localparam int CW = etsf_pkg::ACC_W;
   localparam int GW = etsf_pkg::GPROD_W;
   localparam int KW = etsf_pkg::COEF_W;

   logic signed [SW-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic signed [DW-1:0] e0_ff, e0_in, e1_ff, e1_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [CW-1:0] acc_ff, acc_in;
   logic signed [GW-1:0] gprod_ff, gprod_in;

   logic [etsf_pkg::TERM_W-1:0] term, term_done;
   logic                        phase1;
   logic signed [KW-1:0]        coef;
   logic signed [DW-1:0]        x0_ext, x1_ext, op_u, op_v;
   logic signed [AW-1:0]        mul_a;
   logic signed [DW-1:0]        mul_b;
   logic signed [PW-1:0]        mul_res;
   logic signed [CW-1:0]        prod_ext;
   logic                        acc_step;

   // operand capture: sample and error against the latched state
   always_comb begin
      x0_in = x0_ff;
      x1_in = x1_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      if (ctrl.load_x) begin
         x0_in = state_first;
         x1_in = state_second;
         e0_in = {latched_first[SW-1], latched_first} - {state_first[SW-1], state_first};
         e1_in = {latched_second[SW-1], latched_second} - {state_second[SW-1], state_second};
      end
   end

   // each form term takes two steps: coef*u, then that product times v
   always_comb begin
      term   = ctrl.step[etsf_pkg::STEP_W-1:1];
      phase1 = ctrl.step[0];
      x0_ext = {x0_ff[SW-1], x0_ff};
      x1_ext = {x1_ff[SW-1], x1_ff};
      unique case (term)
         etsf_pkg::TERM_PSI_00: begin
            coef = regs.psi[KW-1:0];      op_u = x0_ext; op_v = x0_ext;
         end
         etsf_pkg::TERM_PSI_01: begin
            coef = regs.psi[2*KW-1:KW];   op_u = x0_ext; op_v = x1_ext;
         end
         etsf_pkg::TERM_PSI_11: begin
            coef = regs.psi[3*KW-1:2*KW]; op_u = x1_ext; op_v = x1_ext;
         end
         etsf_pkg::TERM_XI_00: begin
            coef = regs.xi[KW-1:0];       op_u = e0_ff;  op_v = e0_ff;
         end
         etsf_pkg::TERM_XI_01: begin
            coef = regs.xi[2*KW-1:KW];    op_u = e0_ff;  op_v = e1_ff;
         end
         etsf_pkg::TERM_XI_11: begin
            coef = regs.xi[3*KW-1:2*KW];  op_u = e1_ff;  op_v = e1_ff;
         end
         default: begin
            // gain steps: gain_first*x0, then gain_second*x1
            coef = phase1 ? regs.gain_second : regs.gain_first;
            op_u = x0_ext;
            op_v = x1_ext;
         end
      endcase

      if (phase1 && (term != etsf_pkg::TERM_GAIN)) begin
         mul_a = prod_ff[AW-1:0];
      end else begin
         mul_a = {{(AW-KW){coef[KW-1]}}, coef};
      end
      mul_b   = phase1 ? op_v : op_u;
      mul_res = mul_a * mul_b;
      prod_in = ctrl.mul_en ? mul_res : prod_ff;
   end

   // accumulate psi minus xi from the registered product of each finished term
   always_comb begin
      term_done = term - etsf_pkg::TERM_W'(1);
      prod_ext  = {{(CW-PW){prod_ff[PW-1]}}, prod_ff};
      acc_step  = ctrl.mul_en && !phase1 &&
                  (ctrl.step >= etsf_pkg::STEP_ACC_FIRST) &&
                  (ctrl.step <= etsf_pkg::STEP_ACC_LAST);
      acc_in    = acc_ff;
      if (ctrl.load_x) begin
         acc_in = '0;
      end else if (acc_step) begin
         acc_in = (term_done >= etsf_pkg::TERM_XI_00) ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
      gprod_in = gprod_ff;
      if (ctrl.mul_en && (ctrl.step == etsf_pkg::STEP_GAIN_SECOND)) begin
         gprod_in = prod_ff[GW-1:0];
      end
   end

   assign acc_neg  = acc_ff[CW-1];
   assign ctrl_sum = {{(etsf_pkg::CTRL_W-GW){gprod_ff[GW-1]}}, gprod_ff} +
                     {{(etsf_pkg::CTRL_W-GW){prod_ff[GW-1]}}, prod_ff[GW-1:0]};
   assign x_first  = x0_ff;
   assign x_second = x1_ff;

   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      e0_ff    <= e0_in;
      e1_ff    <= e1_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      gprod_ff <= gprod_in;
   end

endmodule

@@ design/event_triggered_state_feedback_core.sv @@
// top level of the event-triggered state feedback core with quadratic trigger
// depends on etsf_pkg, etsf_channels, etsf_csr, etsf_seq, etsf_datapath
//
//  channel | direction | carries
//  req_ch  | in        | one sampled state (state_first, state_second), Q4.11
//  rsp_ch  | out       | event flag, cause, held control Q14.19, latched state
//  csr_ch  | in        | register index and write data, always ready
//
// each item passes through the accept cycle, 14 steps of the shared 33x17
// multiplier (six form terms at two steps each, two gain products), one final step
// the result sits in an output register; the final step waits while it is not taken
// synchronous active-high reset: registers to defaults, first sample forces an event
// req_ready is high only while the sequencer is idle
`include "event_triggered_state_feedback_core_assert.svh"

module event_triggered_state_feedback_core (
   input  logic        clock,
   input  logic        reset,
   etsf_req_if.sink    req_ch,
   etsf_rsp_if.source  rsp_ch,
   etsf_csr_if.sink    csr_ch
);

   localparam int SW = etsf_pkg::STATE_W;
   localparam int CW = etsf_pkg::CTRL_W;
   localparam int NW = etsf_pkg::CNT_W;

   etsf_pkg::csr_regs_type regs;
   etsf_pkg::dp_ctrl_type  seq_ctrl;

   // trigger state
   logic signed [SW-1:0] latched_first_ff, latched_first_in;
   logic signed [SW-1:0] latched_second_ff, latched_second_in;
   logic signed [CW-1:0] held_control_ff, held_control_in;
   logic [NW-1:0]        count_ff, count_in;
   logic                 first_pending_ff, first_pending_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 event_fired_ff, event_fired_in;
   logic [1:0]           event_cause_ff, event_cause_in;
   logic signed [CW-1:0] control_ff, control_in;
   logic signed [SW-1:0] held_first_ff, held_first_in;
   logic signed [SW-1:0] held_second_ff, held_second_in;

   logic                 out_free;
   logic                 acc_neg;
   logic signed [CW-1:0] ctrl_sum;
   logic signed [SW-1:0] x_first, x_second;
   logic [NW-1:0]        count_inc;
   etsf_pkg::cause_type  cause;

   etsf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .regs  (regs)
   );

   etsf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .out_free  (out_free),
      .req_ready (req_ch.ready),
      .ctrl      (seq_ctrl)
   );

   etsf_datapath u_dp (
      .clock          (clock),
      .ctrl           (seq_ctrl),
      .regs           (regs),
      .state_first    (req_ch.state_first),
      .state_second   (req_ch.state_second),
      .latched_first  (latched_first_ff),
      .latched_second (latched_second_ff),
      .acc_neg        (acc_neg),
      .ctrl_sum       (ctrl_sum),
      .x_first        (x_first),
      .x_second       (x_second)
   );

   // output slot can take a new item if empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // trigger decision: first sample, then psi < xi, then inter-event limit
   always_comb begin
      count_inc = (count_ff == '1) ? count_ff : count_ff + NW'(1);
      if (first_pending_ff) begin
         cause = etsf_pkg::CAUSE_FIRST;
      end else if (acc_neg) begin
         cause = etsf_pkg::CAUSE_QUAD;
      end else if (count_inc >= regs.iet_max) begin
         cause = etsf_pkg::CAUSE_LIMIT;
      end else begin
         cause = etsf_pkg::CAUSE_NONE;
      end
   end

   // state update on the final step
   always_comb begin
      latched_first_in  = latched_first_ff;
      latched_second_in = latched_second_ff;
      held_control_in   = held_control_ff;
      count_in          = count_ff;
      first_pending_in  = first_pending_ff;
      if (seq_ctrl.finish) begin
         if (cause != etsf_pkg::CAUSE_NONE) begin
            // event: latch sample, recompute control, restart the count
            latched_first_in  = x_first;
            latched_second_in = x_second;
            held_control_in   = ctrl_sum;
            count_in          = '0;
            first_pending_in  = 1'b0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   // output register loads the post-step view
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      event_fired_in = event_fired_ff;
      event_cause_in = event_cause_ff;
      control_in     = control_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      if (seq_ctrl.finish) begin
         rsp_valid_in   = 1'b1;
         event_fired_in = (cause != etsf_pkg::CAUSE_NONE);
         event_cause_in = cause;
         control_in     = held_control_in;
         held_first_in  = latched_first_in;
         held_second_in = latched_second_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.event_fired   = event_fired_ff;
   assign rsp_ch.event_cause   = event_cause_ff;
   assign rsp_ch.control_value = control_ff;
   assign rsp_ch.held_first    = held_first_ff;
   assign rsp_ch.held_second   = held_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_first_ff  <= '0;
         latched_second_ff <= '0;
         held_control_ff   <= '0;
         count_ff          <= '0;
         first_pending_ff  <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         latched_first_ff  <= latched_first_in;
         latched_second_ff <= latched_second_in;
         held_control_ff   <= held_control_in;
         count_ff          <= count_in;
         first_pending_ff  <= first_pending_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      event_fired_ff <= event_fired_in;
      event_cause_ff <= event_cause_in;
      control_ff     <= control_in;
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
   end

   `ETSF_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "input accepted while an item is in flight")
   `ETSF_ASSERT_NOW(a_finish_slot_free, seq_ctrl.finish, !rsp_valid_ff || rsp_ch.ready, "result overwrote an item not yet taken")
   `ETSF_ASSERT_NEXT(a_event_clears_count, seq_ctrl.finish && (cause != etsf_pkg::CAUSE_NONE), (count_ff == '0) && !first_pending_ff, "event did not clear the sample count")
   `ETSF_ASSERT_NOW(a_flag_matches_cause, rsp_valid_ff, event_fired_ff == (event_cause_ff != etsf_pkg::CAUSE_NONE), "event flag disagrees with cause")
   `ETSF_ASSERT_NOW(a_first_served, rsp_valid_ff, !first_pending_ff, "result shown while first-sample event still pending")

endmodule

@@ dv/tb_event_triggered_state_feedback_core.sv @@
// self-checking testbench for event_triggered_state_feedback_core: directed plan, then random phases
// depends on etsf_pkg and the etsf_channels interfaces; predicts every result item in-house
`timescale 1ns / 100ps

module tb_event_triggered_state_feedback_core;

   // one result item as the block reports it
   typedef struct {
      logic                                fired;
      etsf_pkg::cause_type                 cause;
      logic signed [etsf_pkg::CTRL_W-1:0]  control;
      logic signed [etsf_pkg::STATE_W-1:0] held_first;
      logic signed [etsf_pkg::STATE_W-1:0] held_second;
   } feedback_result_type;

   // one row of the directed plan: a register write or a sample item
   typedef enum logic {
      ROW_CSR,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [etsf_pkg::CSR_IDX_W-1:0]      idx;
      logic [etsf_pkg::CFG_W-1:0]          data;
      logic signed [etsf_pkg::STATE_W-1:0] s0;
      logic signed [etsf_pkg::STATE_W-1:0] s1;
      logic                                typed;
      feedback_result_type                 res;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   etsf_req_if req_ch ();
   etsf_rsp_if rsp_ch ();
   etsf_csr_if csr_ch ();

   event_triggered_state_feedback_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // predictor copy of the registers, reset values
   logic [etsf_pkg::CFG_W-1:0]          cfg_psi = '0;
   logic [etsf_pkg::CFG_W-1:0]          cfg_xi = '0;
   logic signed [etsf_pkg::COEF_W-1:0]  cfg_gain_first = '0;
   logic signed [etsf_pkg::COEF_W-1:0]  cfg_gain_second = '0;
   logic [etsf_pkg::CNT_W-1:0]          cfg_iet_max = etsf_pkg::IET_RESET;

   // predictor copy of the feedback law state
   logic signed [etsf_pkg::STATE_W-1:0] law_held_first = '0;
   logic signed [etsf_pkg::STATE_W-1:0] law_held_second = '0;
   logic signed [etsf_pkg::CTRL_W-1:0]  law_control = '0;
   logic [etsf_pkg::CNT_W-1:0]          law_count = '0;
   logic                                law_first_pending = 1'b1;

   feedback_result_type expected_feedback[$];
   plan_row_type        directed_plan[$];
   int                  mismatch_count = 0;
   bit                  no_idle = 1'b0;

   // typed-in expectation that travels with the sample item being offered
   logic                typed_now;
   feedback_result_type typed_res;

   // quadratic form c00*a^2 + c01*a*b + c11*b^2, exact in 64 bits (stays under 2^50)
   function automatic longint quad_energy(input logic [etsf_pkg::CFG_W-1:0] coefs,
                                          input longint a, input longint b);
      longint c00, c01, c11;
      c00 = longint'($signed(coefs[15:0]));
      c01 = longint'($signed(coefs[31:16]));
      c11 = longint'($signed(coefs[47:32]));
      return c00 * a * a + c01 * a * b + c11 * b * b;
   endfunction

   // one sampling instant of the feedback law: trigger test, latch, control update
   function automatic feedback_result_type step_feedback_law(
      input logic signed [etsf_pkg::STATE_W-1:0] x0,
      input logic signed [etsf_pkg::STATE_W-1:0] x1);
      feedback_result_type r;
      longint              err0, err1, state_energy, error_energy, ctl;
      etsf_pkg::cause_type cause;
      err0 = longint'(law_held_first) - longint'(x0);
      err1 = longint'(law_held_second) - longint'(x1);
      state_energy = quad_energy(cfg_psi, longint'(x0), longint'(x1));
      error_energy = quad_energy(cfg_xi, err0, err1);
      // count saturates at all ones
      if (law_count != {etsf_pkg::CNT_W{1'b1}})
         law_count = law_count + 1'b1;
      // first sample beats the quadratic test, which beats the limit
      if (law_first_pending)
         cause = etsf_pkg::CAUSE_FIRST;
      else if (state_energy < error_energy)
         cause = etsf_pkg::CAUSE_QUAD;
      else if (law_count >= cfg_iet_max)
         cause = etsf_pkg::CAUSE_LIMIT;
      else
         cause = etsf_pkg::CAUSE_NONE;
      if (cause != etsf_pkg::CAUSE_NONE) begin
         ctl = longint'(cfg_gain_first) * longint'(x0) +
               longint'(cfg_gain_second) * longint'(x1);
         law_held_first = x0;
         law_held_second = x1;
         law_control = ctl[etsf_pkg::CTRL_W-1:0];
         law_count = '0;
         law_first_pending = 1'b0;
      end
      r.fired = (cause != etsf_pkg::CAUSE_NONE);
      r.cause = cause;
      r.control = law_control;
      r.held_first = law_held_first;
      r.held_second = law_held_second;
      return r;
   endfunction

   // watch accepted register writes and sample items, keep the predictor in step
   always @(posedge clock) begin : track_inputs
      feedback_result_type predicted;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               etsf_pkg::CSR_PSI:         cfg_psi = csr_ch.wdata;
               etsf_pkg::CSR_XI:          cfg_xi = csr_ch.wdata;
               etsf_pkg::CSR_GAIN_FIRST:  cfg_gain_first = csr_ch.wdata[etsf_pkg::COEF_W-1:0];
               etsf_pkg::CSR_GAIN_SECOND: cfg_gain_second = csr_ch.wdata[etsf_pkg::COEF_W-1:0];
               etsf_pkg::CSR_IET_MAX:     cfg_iet_max = csr_ch.wdata[etsf_pkg::CNT_W-1:0];
               default: ;  // unused indexes write nothing
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = step_feedback_law(req_ch.state_first, req_ch.state_second);
            // a row with a typed-in result is held to that instead
            if (typed_now)
               expected_feedback = {expected_feedback, typed_res};
            else
               expected_feedback = {expected_feedback, predicted};
         end
      end
   end

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : check_results
      feedback_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_feedback.size() == 0) begin
            $error("result item with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_feedback.pop_front();
            if (rsp_ch.event_fired !== want.fired) begin
               $error("event_fired expected %0d got %0d", want.fired, rsp_ch.event_fired);
               mismatch_count++;
            end
            if (rsp_ch.event_cause !== want.cause) begin
               $error("event_cause expected %0d got %0d", want.cause, rsp_ch.event_cause);
               mismatch_count++;
            end
            if (rsp_ch.control_value !== want.control) begin
               $error("control_value expected %0d got %0d", want.control, rsp_ch.control_value);
               mismatch_count++;
            end
            if (rsp_ch.held_first !== want.held_first) begin
               $error("held_first expected %0d got %0d", want.held_first, rsp_ch.held_first);
               mismatch_count++;
            end
            if (rsp_ch.held_second !== want.held_second) begin
               $error("held_second expected %0d got %0d", want.held_second, rsp_ch.held_second);
               mismatch_count++;
            end
         end
      end
   end

   // result side backpressure: ready drops about 7 percent of the time, never in the no-idle stretch
   initial begin : drive_result_ready
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 7);
      end
   end

   // directed plan builders
   function automatic void add_csr(input logic [etsf_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [etsf_pkg::CFG_W-1:0] data);
      plan_row_type row;
      row.kind = ROW_CSR;
      row.idx = idx;
      row.data = data;
      row.typed = 1'b0;
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void add_sample(input logic signed [etsf_pkg::STATE_W-1:0] s0,
                                      input logic signed [etsf_pkg::STATE_W-1:0] s1);
      plan_row_type row;
      row.kind = ROW_SAMPLE;
      row.s0 = s0;
      row.s1 = s1;
      row.typed = 1'b0;
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void add_typed(input logic signed [etsf_pkg::STATE_W-1:0] s0,
                                     input logic signed [etsf_pkg::STATE_W-1:0] s1,
                                     input etsf_pkg::cause_type cause,
                                     input logic signed [etsf_pkg::CTRL_W-1:0] ctrl,
                                     input logic signed [etsf_pkg::STATE_W-1:0] h0,
                                     input logic signed [etsf_pkg::STATE_W-1:0] h1);
      plan_row_type row;
      row.kind = ROW_SAMPLE;
      row.s0 = s0;
      row.s1 = s1;
      row.typed = 1'b1;
      row.res.fired = (cause != etsf_pkg::CAUSE_NONE);
      row.res.cause = cause;
      row.res.control = ctrl;
      row.res.held_first = h0;
      row.res.held_second = h1;
      directed_plan = {directed_plan, row};
   endfunction

   // stop offering items and wait until every expected result item has come back
   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      // wait for the clock edge so an item accepted this cycle is already queued
      @(posedge clock);
      while (expected_feedback.size() != 0)
         @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(input logic [etsf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [etsf_pkg::CFG_W-1:0] data);
      wait_results_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // offer one sample item; valid stays up on return so back-to-back items need no toggle
   task automatic send_sample(input logic signed [etsf_pkg::STATE_W-1:0] s0,
                              input logic signed [etsf_pkg::STATE_W-1:0] s1, input logic typed,
                              input feedback_result_type res);
      // occasional gap, long enough to land on any step of the block's work
      if (!no_idle && $urandom_range(0, 99) < 7) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 20))
            @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.state_first <= s0;
      req_ch.state_second <= s1;
      typed_now <= typed;
      typed_res <= res;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   // random coefficient or gain, extremes favored
   function automatic logic [etsf_pkg::COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return etsf_pkg::COEF_W'($urandom_range(1, 512));
         4: return etsf_pkg::COEF_W'(-$urandom_range(1, 512));
         default: return etsf_pkg::COEF_W'($urandom);
      endcase
   endfunction

   // random event limit: mostly short so the limit cause shows up often
   function automatic logic [etsf_pkg::CNT_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3, 4, 5, 6: return etsf_pkg::CNT_W'($urandom_range(2, 12));
         7: return etsf_pkg::CNT_W'($urandom_range(13, 60));
         default: return etsf_pkg::CNT_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      feedback_result_type                 blank;
      logic signed [etsf_pkg::STATE_W-1:0] last_first, last_second, a, b;
      int                                  mode;

      req_ch.valid <= 1'b0;
      req_ch.state_first <= '0;
      req_ch.state_second <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.wdata <= '0;
      typed_now <= 1'b0;
      last_first = '0;
      last_second = '0;

      repeat (11)
         @(posedge clock);
      reset <= 1'b0;

      // first sample forced even though the error form alone would trigger
      add_csr(etsf_pkg::CSR_XI, 48'h7FFF_7FFF_7FFF);
      add_csr(etsf_pkg::CSR_GAIN_FIRST, 48'h7FFF);
      add_csr(etsf_pkg::CSR_GAIN_SECOND, 48'h8000);
      add_typed(16'sh7FFF, 16'sh8000, etsf_pkg::CAUSE_FIRST, 34'sh0_7FFF_0001,
                16'sh7FFF, 16'sh8000);
      // same state again: zero error, count still under the reset limit
      add_typed(16'sh7FFF, 16'sh8000, etsf_pkg::CAUSE_NONE, 34'sh0_7FFF_0001,
                16'sh7FFF, 16'sh8000);
      // limit of zero: every sample is an event
      add_csr(etsf_pkg::CSR_XI, 48'h0);
      add_csr(etsf_pkg::CSR_IET_MAX, 48'h0);
      add_typed(16'sh8000, 16'sh8000, etsf_pkg::CAUSE_LIMIT, 34'sh8000, 16'sh8000, 16'sh8000);
      // most negative gains against state extremes, widest control values
      add_csr(etsf_pkg::CSR_GAIN_FIRST, 48'h8000);
      add_csr(etsf_pkg::CSR_GAIN_SECOND, 48'h8000);
      add_typed(16'sh8000, 16'sh8000, etsf_pkg::CAUSE_LIMIT, 34'sh0_8000_0000,
                16'sh8000, 16'sh8000);
      add_typed(16'sh7FFF, 16'sh7FFF, etsf_pkg::CAUSE_LIMIT, -34'sd2147418112,
                16'sh7FFF, 16'sh7FFF);
      // quadratic trigger on a full-scale jump, with the limit at its maximum
      add_csr(etsf_pkg::CSR_XI, 48'h7FFF_7FFF_7FFF);
      add_csr(etsf_pkg::CSR_IET_MAX, 48'hFFFF);
      add_typed(16'sh8000, 16'sh8000, etsf_pkg::CAUSE_QUAD, 34'sh0_8000_0000,
                16'sh8000, 16'sh8000);
      add_typed(16'sh8000, 16'sh8000, etsf_pkg::CAUSE_NONE, 34'sh0_8000_0000,
                16'sh8000, 16'sh8000);
      // unused indexes must leave everything alone
      add_csr(3'd5, {etsf_pkg::CFG_W{1'b1}});
      add_csr(3'd7, {etsf_pkg::CFG_W{1'b1}});
      add_typed(16'sh8000, 16'sh8000, etsf_pkg::CAUSE_NONE, 34'sh0_8000_0000,
                16'sh8000, 16'sh8000);
      // most negative coefficients everywhere, limit of one
      add_csr(etsf_pkg::CSR_PSI, 48'h8000_8000_8000);
      add_csr(etsf_pkg::CSR_XI, 48'h8000_8000_8000);
      add_csr(etsf_pkg::CSR_IET_MAX, 48'd1);
      add_sample(16'sh7FFF, 16'sh8000);
      add_sample(16'sh0000, 16'sh0000);
      add_sample(16'sh1234, 16'shF013);
      add_sample(16'sh0001, 16'shFFFF);
      // plain positive forms: trigger when the error grows past half the state
      add_csr(etsf_pkg::CSR_PSI, 48'h0100_0000_0100);
      add_csr(etsf_pkg::CSR_XI, 48'h0400_0000_0400);
      add_csr(etsf_pkg::CSR_IET_MAX, 48'd3);
      add_csr(etsf_pkg::CSR_GAIN_FIRST, 48'h7FFF);
      add_csr(etsf_pkg::CSR_GAIN_SECOND, 48'h7FFF);
      add_sample(16'sh0800, 16'sh0800);
      add_sample(16'sh0810, 16'sh07F0);
      add_sample(16'sh0500, 16'sh0900);
      add_sample(16'sh0500, 16'sh0900);
      add_sample(16'sh0500, 16'sh0900);
      add_sample(16'sh0500, 16'sh0900);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR)
            write_reg(directed_plan[i].idx, directed_plan[i].data);
         else begin
            send_sample(directed_plan[i].s0, directed_plan[i].s1, directed_plan[i].typed,
                        directed_plan[i].res);
            last_first = directed_plan[i].s0;
            last_second = directed_plan[i].s1;
         end
      end

      // random phases: fresh settings between phases, then a burst of samples
      for (int phase = 0; phase < 20; phase++) begin
         // one long stretch with no idling on either side
         no_idle = (phase >= 9 && phase <= 11);
         if (phase == 0 || $urandom_range(0, 9) < 6)
            write_reg(etsf_pkg::CSR_PSI, {pick_coef(), pick_coef(), pick_coef()});
         if (phase == 0 || $urandom_range(0, 9) < 6)
            write_reg(etsf_pkg::CSR_XI, {pick_coef(), pick_coef(), pick_coef()});
         if (phase == 0 || $urandom_range(0, 9) < 6)
            write_reg(etsf_pkg::CSR_GAIN_FIRST, etsf_pkg::CFG_W'(pick_coef()));
         if (phase == 0 || $urandom_range(0, 9) < 6)
            write_reg(etsf_pkg::CSR_GAIN_SECOND, etsf_pkg::CFG_W'(pick_coef()));
         if (phase == 0 || $urandom_range(0, 9) < 7)
            write_reg(etsf_pkg::CSR_IET_MAX, etsf_pkg::CFG_W'(pick_limit()));
         if ($urandom_range(0, 9) == 0)
            write_reg(etsf_pkg::CSR_IDX_W'($urandom_range(5, 7)),
                      etsf_pkg::CFG_W'({$urandom, $urandom}));

         for (int n = 0; n < 40; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 15) begin
               // anywhere in range
               a = etsf_pkg::STATE_W'($urandom);
               b = etsf_pkg::STATE_W'($urandom);
            end else if (mode < 35) begin
               // hold still so the count runs toward the limit
               a = last_first;
               b = last_second;
            end else if (mode < 80) begin
               // slow drift around the last sample
               a = last_first + etsf_pkg::STATE_W'($urandom_range(0, 128)) - 16'sd64;
               b = last_second + etsf_pkg::STATE_W'($urandom_range(0, 128)) - 16'sd64;
            end else if (mode < 90) begin
               // corners
               case ($urandom_range(0, 3))
                  0: a = 16'sh7FFF;
                  1: a = 16'sh8000;
                  2: a = 16'sh0000;
                  default: a = 16'shFFFF;
               endcase
               case ($urandom_range(0, 3))
                  0: b = 16'sh7FFF;
                  1: b = 16'sh8000;
                  2: b = 16'sh0000;
                  default: b = 16'shFFFF;
               endcase
            end else begin
               // small values near the origin
               a = etsf_pkg::STATE_W'($urandom_range(0, 255)) - 16'sd128;
               b = etsf_pkg::STATE_W'($urandom_range(0, 255)) - 16'sd128;
            end
            send_sample(a, b, 1'b0, blank);
            last_first = a;
            last_second = b;
         end
      end

      no_idle = 1'b0;
      wait_results_drained();
      // room for any stray result item
      repeat (40)
         @(posedge clock);
      if (mismatch_count == 0 && expected_feedback.size() == 0)
         $display("event_triggered_state_feedback_core: match");
      else
         $display("event_triggered_state_feedback_core: mismatch");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : run_limit
      #20000000;
      $display("event_triggered_state_feedback_core: mismatch");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/etsf_pkg.sv
design/etsf_channels.sv
design/etsf_csr.sv
design/etsf_seq.sv
design/etsf_datapath.sv
design/event_triggered_state_feedback_core.sv
dv/tb_event_triggered_state_feedback_core.sv
